// ----- hdl/owm_pkg.sv -----
// owm_pkg: shared types, phase codes, register indexes and timing helpers
// for the multi-line one-wire master; depends on nothing
package owm_pkg;

  // number of lines actually wired up, the field widths stay at sixteen
  localparam int unsigned LINE_COUNT = 16;
  localparam int unsigned READ_SAMPLE_DELAY = 13;
  localparam int unsigned LINES_USED = (LINE_COUNT >= 16) ? 16 : LINE_COUNT;
  localparam logic [15:0] LINE_AVAIL = 16'((33'd1 << LINES_USED) - 33'd1);
  localparam logic [9:0] RD_WAIT_TIME = 10'(READ_SAMPLE_DELAY);

  // longest run of zero-length phases one tick can pass through
  localparam int unsigned CHAIN_STEPS = 5;

  // command codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_RESET = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_RECOVERY     = 3'd0;
  localparam logic [2:0] CFG_WRITE_SLOT   = 3'd1;
  localparam logic [2:0] CFG_READ_SLOT    = 3'd2;
  localparam logic [2:0] CFG_RESET_HIGH   = 3'd3;
  localparam logic [2:0] CFG_RESET_LOW    = 3'd4;
  localparam logic [2:0] CFG_PRES_SAMPLE  = 3'd5;
  localparam logic [2:0] CFG_PRES_CHECK   = 3'd6;
  localparam logic [2:0] CFG_RESET_TAIL   = 3'd7;

  // bus phases
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_RST_HIGH   = 4'd1;
  localparam logic [3:0] PH_RST_LOW    = 4'd2;
  localparam logic [3:0] PH_RST_SAMPLE = 4'd3;
  localparam logic [3:0] PH_RST_CHECK  = 4'd4;
  localparam logic [3:0] PH_RST_TAIL   = 4'd5;
  localparam logic [3:0] PH_WR_LOW     = 4'd6;
  localparam logic [3:0] PH_WR_SLOT    = 4'd7;
  localparam logic [3:0] PH_RD_LOW     = 4'd8;
  localparam logic [3:0] PH_RD_WAIT    = 4'd9;
  localparam logic [3:0] PH_RD_SLOT    = 4'd10;

  typedef struct packed {
    logic [3:0] recovery_time;
    logic [7:0] write_slot_time;
    logic [7:0] read_slot_time;
    logic [9:0] reset_high_time;
    logic [9:0] reset_low_time;
    logic [7:0] presence_sample_time;
    logic [9:0] presence_check_time;
    logic [9:0] reset_tail_time;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [9:0]  timer;
    logic [15:0] active;
    logic        send;
    logic [15:0] store;
  } seq_t;

  typedef struct packed {
    seq_t        seq;
    logic        done;
    logic [15:0] res;
  } adv_t;

  typedef struct packed {
    logic [15:0] drive_low;
    logic        busy;
    logic        done;
    logic [15:0] result;
  } res_t;

  function automatic logic [9:0] phase_dur(input logic [3:0] ph, input cfg_t c);
    case (ph)
      PH_RST_HIGH:   phase_dur = c.reset_high_time;
      PH_RST_LOW:    phase_dur = c.reset_low_time;
      PH_RST_SAMPLE: phase_dur = 10'(c.presence_sample_time);
      PH_RST_CHECK:  phase_dur = c.presence_check_time;
      PH_RST_TAIL:   phase_dur = c.reset_tail_time;
      PH_WR_LOW:     phase_dur = 10'(c.recovery_time);
      PH_WR_SLOT:    phase_dur = 10'(c.write_slot_time);
      PH_RD_LOW:     phase_dur = 10'(c.recovery_time);
      PH_RD_WAIT:    phase_dur = RD_WAIT_TIME;
      PH_RD_SLOT:    phase_dur = 10'(c.read_slot_time);
      default:       phase_dur = 10'd0;
    endcase
  endfunction

  // one phase change if the current phase has run out, else no change
  function automatic adv_t phase_adv(input seq_t s, input logic [15:0] sense,
                                     input cfg_t c);
    adv_t       a;
    logic [3:0] nxt;
    a      = '0;
    a.seq  = s;
    nxt    = s.phase;
    if (s.phase != PH_IDLE && s.timer == 10'd0) begin
      case (s.phase)
        PH_RST_HIGH: nxt = PH_RST_LOW;
        PH_RST_LOW:  nxt = PH_RST_SAMPLE;
        PH_RST_SAMPLE: begin
          a.seq.store = sense;
          nxt = PH_RST_CHECK;
        end
        PH_RST_CHECK: begin
          a.seq.store = s.active & ~s.store & sense;
          nxt = PH_RST_TAIL;
        end
        PH_RST_TAIL: begin
          a.done = 1'b1;
          a.res  = s.store;
          nxt    = PH_IDLE;
        end
        PH_WR_LOW: nxt = PH_WR_SLOT;
        PH_WR_SLOT: begin
          a.done = 1'b1;
          nxt    = PH_IDLE;
        end
        PH_RD_LOW: nxt = PH_RD_WAIT;
        PH_RD_WAIT: begin
          a.seq.store = sense & s.active;
          nxt = PH_RD_SLOT;
        end
        PH_RD_SLOT: begin
          a.done = 1'b1;
          a.res  = s.store;
          nxt    = PH_IDLE;
        end
        default: nxt = PH_IDLE;
      endcase
      a.seq.phase = nxt;
      a.seq.timer = phase_dur(nxt, c);
    end
    return a;
  endfunction

endpackage

// ----- hdl/owm_cfg_regs.sv -----
// owm_cfg_regs: timing register file written through the config port
// depends on owm_pkg
module owm_cfg_regs
  import owm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_idx,
  input  logic [9:0] cfg_wdata,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_RECOVERY:    cfg_nxt.recovery_time        = cfg_wdata[3:0];
        CFG_WRITE_SLOT:  cfg_nxt.write_slot_time      = cfg_wdata[7:0];
        CFG_READ_SLOT:   cfg_nxt.read_slot_time       = cfg_wdata[7:0];
        CFG_RESET_HIGH:  cfg_nxt.reset_high_time      = cfg_wdata;
        CFG_RESET_LOW:   cfg_nxt.reset_low_time       = cfg_wdata;
        CFG_PRES_SAMPLE: cfg_nxt.presence_sample_time = cfg_wdata[7:0];
        CFG_PRES_CHECK:  cfg_nxt.presence_check_time  = cfg_wdata;
        CFG_RESET_TAIL:  cfg_nxt.reset_tail_time      = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.recovery_time        <= 4'd2;
      cfg_r.write_slot_time      <= 8'd60;
      cfg_r.read_slot_time       <= 8'd45;
      cfg_r.reset_high_time      <= 10'd250;
      cfg_r.reset_low_time       <= 10'd550;
      cfg_r.presence_sample_time <= 8'd70;
      cfg_r.presence_check_time  <= 10'd300;
      cfg_r.reset_tail_time      <= 10'd250;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/owm_core.sv -----
// owm_core: bus sequencer state and the per-tick phase logic
// depends on owm_pkg
module owm_core
  import owm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [1:0]  func,
  input  logic [15:0] line_mask,
  input  logic        write_bit,
  input  logic [15:0] line_sense,
  input  cfg_t        cfg,
  output res_t        res
);

  seq_t seq_r;
  seq_t seq_nxt;
  seq_t seq_start;
  seq_t chain [CHAIN_STEPS+1];
  adv_t adv   [CHAIN_STEPS];
  logic        done_any;
  logic [15:0] res_any;
  logic        drive_on;
  seq_t        fin;

  always_comb begin
    // command start, only taken while idle
    seq_start = seq_r;
    if (seq_r.phase == PH_IDLE && func != FUNC_TICK) begin
      seq_start.active = line_mask & LINE_AVAIL;
      seq_start.send   = write_bit;
      case (func)
        FUNC_RESET: seq_start.phase = PH_RST_HIGH;
        FUNC_WRITE: seq_start.phase = PH_WR_LOW;
        default:    seq_start.phase = PH_RD_LOW;
      endcase
      seq_start.timer = phase_dur(seq_start.phase, cfg);
    end

    // pass through phases of zero remaining length
    chain[0] = seq_start;
    done_any = 1'b0;
    res_any  = '0;
    for (int i = 0; i < CHAIN_STEPS; i++) begin
      adv[i]     = phase_adv(chain[i], line_sense, cfg);
      chain[i+1] = adv[i].seq;
      done_any   = done_any | adv[i].done;
      res_any    = res_any | adv[i].res;
    end
    fin = chain[CHAIN_STEPS];

    drive_on = (fin.phase == PH_RST_LOW) || (fin.phase == PH_WR_LOW) ||
               (fin.phase == PH_RD_LOW) || (fin.phase == PH_WR_SLOT && !fin.send);

    res.drive_low = drive_on ? fin.active : 16'd0;
    res.busy      = (fin.phase != PH_IDLE);
    res.done      = done_any;
    res.result    = res_any;

    seq_nxt = fin;
    if (fin.phase != PH_IDLE) begin
      seq_nxt.timer = fin.timer - 10'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
    end else if (step_en) begin
      seq_r <= seq_nxt;
    end
  end

endmodule

// ----- hdl/multi_line_onewire_master.sv -----
// multi_line_onewire_master: top level, input register, result register
// depends on owm_pkg, owm_cfg_regs and owm_core
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid in_stall in_func in_line_mask       | to block
//          | in_write_bit in_line_sense                   |
//  out     | out_valid out_stall out_drive_low            | from block
//          | out_busy_res out_done_res out_result         |
//  cfg     | cfg_we cfg_idx cfg_wdata                     | to block
//
// every input beat is one microsecond tick and yields exactly one output beat
// a beat is held in the input register, the sequencer step runs between
// that register and the result register, one beat/cycle while out_stall is low
// zero-length phases are all passed through inside that single step
// synchronous active-low reset clears both stages and puts the bus in idle
// out_stall holds the result register, and in_stall rises only while both stages
// are full and the result is stalled
module multi_line_onewire_master
  import owm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_line_mask,
  input  logic        in_write_bit,
  input  logic [15:0] in_line_sense,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_drive_low,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [15:0] out_result,
  // configuration port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [9:0]  cfg_wdata
);

  // input register
  logic        in_vld_r;
  logic        in_vld_nxt;
  logic [1:0]  func_r;
  logic [15:0] mask_r;
  logic        wbit_r;
  logic [15:0] sense_r;

  // result register
  logic        out_vld_r;
  logic        out_vld_nxt;
  res_t        res_r;

  cfg_t        cfg;
  res_t        step_res;
  logic        in_take;
  logic        step_go;

  owm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // sequencer advances exactly once per beat moving into the result register
  owm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_go),
    .func       (func_r),
    .line_mask  (mask_r),
    .write_bit  (wbit_r),
    .line_sense (sense_r),
    .cfg        (cfg),
    .res        (step_res)
  );

  // handshake control
  assign step_go  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !step_go;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (step_go) begin
      in_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    if (step_go) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r  <= in_func;
      mask_r  <= in_line_mask;
      wbit_r  <= in_write_bit;
      sense_r <= in_line_sense;
    end
    if (step_go) begin
      res_r <= step_res;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_drive_low = res_r.drive_low;
  assign out_busy_res  = res_r.busy;
  assign out_done_res  = res_r.done;
  assign out_result    = res_r.result;

  // back-pressure only comes from a held result beat
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result beat");

  // a finished command leaves the bus idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> !out_busy_res)
    else $error("done reported while still busy");

  // result only carries data on the done beat
  a_result_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_done_res) |-> (out_result == 16'd0))
    else $error("result nonzero without done");

  // lines are never pulled low while idle
  a_idle_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_busy_res) |-> (out_drive_low == 16'd0))
    else $error("lines driven low while idle");

endmodule
